// File: rtl/hfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the header field parser.
// Used by hfp_parse_core and header_field_parser.
package hfp_pkg;

    localparam int unsigned HASH_BUCKETS    = 256;
    localparam int unsigned MAX_BLOCK_BYTES = 65536;

    // Bucket count is a power of two: the modulo is a truncation to HASH_W bits.
    localparam int unsigned HASH_W = $clog2(HASH_BUCKETS);
    localparam int unsigned POS_W  = 16;
    localparam int unsigned OUT_HASH_W = 8;

    // Lengths must fit in 16 bits, so the limit never goes above 65535.
    localparam logic [POS_W-1:0] POS_LIMIT =
        (MAX_BLOCK_BYTES < 65535) ? POS_W'(MAX_BLOCK_BYTES) : POS_W'(65535);

    localparam logic [POS_W-1:0] HASH_MULT = POS_W'(131);
    localparam logic [7:0]       HASH_MASK = 8'h1F;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    typedef enum logic [2:0] {
        ST_NAME  = 3'd0,
        ST_VALUE = 3'd1,
        ST_CR    = 3'd2,
        ST_NL    = 3'd3,
        ST_FIN   = 3'd4,
        ST_END   = 3'd5
    } parse_state_t;

    typedef enum logic [2:0] {
        CL_COLON  = 3'd0,
        CL_CR     = 3'd1,
        CL_LF     = 3'd2,
        CL_SPACE  = 3'd3,
        CL_LETTER = 3'd4,
        CL_OTHER  = 3'd5
    } byte_class_t;

    typedef enum logic [1:0] {
        EV_FIELD = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } event_kind_t;

    typedef enum logic [3:0] {
        ERR_NAME_CR      = 4'd0,
        ERR_NL_COLON     = 4'd1,
        ERR_NL_LF        = 4'd2,
        ERR_NL_OTHER     = 4'd3,
        ERR_FIN_COLON    = 4'd4,
        ERR_FIN_CR       = 4'd5,
        ERR_FIN_SPACE    = 4'd6,
        ERR_FIN_LETTER   = 4'd7,
        ERR_FIN_OTHER    = 4'd8,
        ERR_POS_OVERFLOW = 4'd9
    } error_code_t;

    typedef struct packed {
        logic         err;
        parse_state_t st;
        error_code_t  code;
    } trans_t;

    typedef struct packed {
        logic              valid;
        event_kind_t       kind;
        logic [POS_W-1:0]  name_start;
        logic [POS_W-1:0]  name_length;
        logic [OUT_HASH_W-1:0] name_hash;
        logic [POS_W-1:0]  value_start;
        logic [POS_W-1:0]  value_length;
        logic [POS_W-1:0]  total_length;
        error_code_t       error_code;
    } hfp_event_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if (b == CH_COLON) c = CL_COLON;
        else if (b == CH_CR) c = CL_CR;
        else if (b == CH_LF) c = CL_LF;
        else if (b == CH_SPACE || b == CH_TAB) c = CL_SPACE;
        else if ((b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z))
            c = CL_LETTER;
        else c = CL_OTHER;
        return c;
    endfunction

    function automatic trans_t ok(input parse_state_t s);
        trans_t t;
        t.err  = 1'b0;
        t.st   = s;
        t.code = ERR_NAME_CR;
        return t;
    endfunction

    function automatic trans_t fail(input error_code_t e);
        trans_t t;
        t.err  = 1'b1;
        t.st   = ST_NAME;
        t.code = e;
        return t;
    endfunction

    // Fixed transition table; states outside the table behave as the name state.
    function automatic trans_t next_trans(input parse_state_t s, input byte_class_t c);
        trans_t t;
        unique case (s)
            ST_VALUE: t = (c == CL_COLON) ? ok(ST_VALUE) :
                          (c == CL_CR)    ? ok(ST_CR)    : ok(ST_VALUE);
            ST_CR: begin
                case (c)
                    CL_CR:   t = ok(ST_CR);
                    CL_LF:   t = ok(ST_NL);
                    default: t = ok(ST_VALUE);
                endcase
            end
            ST_NL: begin
                case (c)
                    CL_COLON:  t = fail(ERR_NL_COLON);
                    CL_CR:     t = ok(ST_FIN);
                    CL_LF:     t = fail(ERR_NL_LF);
                    CL_SPACE:  t = ok(ST_VALUE);
                    CL_LETTER: t = ok(ST_NAME);
                    default:   t = fail(ERR_NL_OTHER);
                endcase
            end
            ST_FIN: begin
                case (c)
                    CL_COLON:  t = fail(ERR_FIN_COLON);
                    CL_CR:     t = fail(ERR_FIN_CR);
                    CL_LF:     t = ok(ST_END);
                    CL_SPACE:  t = fail(ERR_FIN_SPACE);
                    CL_LETTER: t = fail(ERR_FIN_LETTER);
                    default:   t = fail(ERR_FIN_OTHER);
                endcase
            end
            default: begin
                case (c)
                    CL_COLON: t = ok(ST_VALUE);
                    CL_CR:    t = fail(ERR_NAME_CR);
                    default:  t = ok(ST_NAME);
                endcase
            end
        endcase
        return t;
    endfunction

    function automatic logic [HASH_W-1:0] hash_add(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W+POS_W-1:0] acc;
        acc = (HASH_W+POS_W)'(h) * (HASH_W+POS_W)'(HASH_MULT)
            + (HASH_W+POS_W)'(b & HASH_MASK);
        return acc[HASH_W-1:0];
    endfunction

endpackage

// File: rtl/hfp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the header field parser: holds one accepted byte word.
// Depends on nothing but the stream handshake.
module hfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_data,
    input  logic       s_start,
    input  logic       advance,
    output logic       valid,
    output logic [7:0] data,
    output logic       start
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       start_reg;

    // Refill whenever the held word moves on or the stage is empty.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            data_reg  <= s_data;
            start_reg <= s_start;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign start = start_reg;

endmodule

// File: rtl/hfp_parse_core.sv
`timescale 1ns / 1ps
// Parse state, position and hash registers plus the per-byte decode.
// Depends on hfp_pkg for the class and transition tables and the event type.
module hfp_parse_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               start_new,
    output hfp_pkg::hfp_event_t ev
);

    hfp_pkg::parse_state_t        state_reg, state_next, state_e;
    logic [hfp_pkg::POS_W-1:0]    pos_reg, pos_next, pos_e;
    logic [hfp_pkg::POS_W-1:0]    nstart_reg, nstart_next, nstart_e;
    logic [hfp_pkg::POS_W-1:0]    nlen_reg, nlen_next, nlen_e;
    logic [hfp_pkg::POS_W-1:0]    vstart_reg, vstart_next, vstart_e;
    logic [hfp_pkg::HASH_W-1:0]   hash_reg, hash_next, hash_e;
    logic                         stopped_reg, stopped_next, stopped_e;
    logic                         per_line_reg;
    hfp_pkg::trans_t              tr;

    always_comb begin
        // A start flag clears the block before this byte is parsed.
        state_e   = start_new ? hfp_pkg::ST_NAME : state_reg;
        pos_e     = start_new ? '0 : pos_reg;
        nstart_e  = start_new ? '0 : nstart_reg;
        nlen_e    = start_new ? '0 : nlen_reg;
        vstart_e  = start_new ? '0 : vstart_reg;
        hash_e    = start_new ? '0 : hash_reg;
        stopped_e = start_new ? 1'b0 : stopped_reg;

        tr = hfp_pkg::next_trans(state_e, hfp_pkg::classify(data_byte));

        state_next   = state_e;
        pos_next     = pos_e;
        nstart_next  = nstart_e;
        nlen_next    = nlen_e;
        vstart_next  = vstart_e;
        hash_next    = hash_e;
        stopped_next = stopped_e;
        ev           = '0;

        if (!stopped_e) begin
            if (pos_e >= hfp_pkg::POS_LIMIT) begin
                ev.valid      = 1'b1;
                ev.kind       = hfp_pkg::EV_ERROR;
                ev.error_code = hfp_pkg::ERR_POS_OVERFLOW;
                stopped_next  = 1'b1;
            end else begin
                pos_next = pos_e + 1'b1;
                if (tr.err) begin
                    ev.valid      = 1'b1;
                    ev.kind       = hfp_pkg::EV_ERROR;
                    ev.error_code = tr.code;
                    stopped_next  = 1'b1;
                end else begin
                    unique case (state_e)
                        hfp_pkg::ST_NAME: begin
                            if (tr.st == hfp_pkg::ST_VALUE) begin
                                vstart_next = pos_e + 1'b1;
                                nlen_next   = pos_e - nstart_e;
                            end else begin
                                hash_next = hfp_pkg::hash_add(hash_e, data_byte);
                            end
                        end
                        hfp_pkg::ST_NL: begin
                            // Folded line in per-field mode: keep the value going.
                            if (!(tr.st == hfp_pkg::ST_VALUE && !per_line_reg)) begin
                                ev.valid        = 1'b1;
                                ev.kind         = hfp_pkg::EV_FIELD;
                                ev.name_start   = nstart_e;
                                ev.name_length  = nlen_e;
                                ev.name_hash    = hfp_pkg::OUT_HASH_W'(hash_e);
                                ev.value_start  = vstart_e;
                                ev.value_length = pos_e - vstart_e - hfp_pkg::POS_W'(2);
                                if (tr.st == hfp_pkg::ST_NAME) begin
                                    nstart_next = pos_e;
                                    hash_next   = hfp_pkg::hash_add('0, data_byte);
                                end else if (tr.st == hfp_pkg::ST_VALUE) begin
                                    vstart_next = pos_e;
                                end
                            end
                        end
                        hfp_pkg::ST_FIN: begin
                            if (tr.st == hfp_pkg::ST_END) begin
                                ev.valid        = 1'b1;
                                ev.kind         = hfp_pkg::EV_END;
                                ev.total_length = pos_e + 1'b1;
                                stopped_next    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_next = (tr.st == hfp_pkg::ST_END) ? hfp_pkg::ST_FIN : tr.st;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_line_reg <= 1'b0;
        end else if (cfg_we) begin
            per_line_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hfp_pkg::ST_NAME;
            pos_reg     <= '0;
            nstart_reg  <= '0;
            nlen_reg    <= '0;
            vstart_reg  <= '0;
            hash_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (step) begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            nstart_reg  <= nstart_next;
            nlen_reg    <= nlen_next;
            vstart_reg  <= vstart_next;
            hash_reg    <= hash_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: rtl/header_field_parser.sv
`timescale 1ns / 1ps
// Top level of the header field parser: input register, parse core, result register.
// Depends on hfp_pkg, hfp_in_stage and hfp_parse_core.
//
//  channel  | direction | tdata                        | tuser
//  ---------+-----------+------------------------------+-------------------
//  s_       | in        | data_byte                    | start_new
//  m_       | out       | bounds, hash, lengths, error | event_kind
//  cfg_     | in        | cfg_wdata: per_line_continuation (no handshake)
//
// One byte word per clock sustained while m_tready is high; each word passes the
// input register and the decode and lands in the result register.
// Each byte gives zero or one result word.
// Reset (aresetn low, synchronous) empties both registers and clears the parse
// state and mode bit. A stalled m_ side holds the result; the input register
// still takes a word only while empty, then s_tready drops until m_tready returns.
module header_field_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_new

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [15:0] name_start, [31:16] name_length,
                                   // [39:32] name_hash, [55:40] value_start,
                                   // [71:56] value_length, [87:72] total_length,
                                   // [91:88] error_code, [95:92] zero
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    logic                 advance;
    logic                 in_valid;
    logic [7:0]           in_data;
    logic                 in_start;
    logic                 step;
    hfp_pkg::hfp_event_t  ev;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [95:0]          m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    assign advance = !m_tvalid_reg || m_tready;
    assign step    = in_valid && advance;

    hfp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata),
        .s_start  (s_tuser),
        .advance  (advance),
        .valid    (in_valid),
        .data     (in_data),
        .start    (in_start)
    );

    hfp_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .data_byte (in_data),
        .start_new (in_start),
        .ev        (ev)
    );

    assign m_tvalid_next = advance ? (step && ev.valid) : m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the result word only when the register is free to move.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {4'b0000, ev.error_code, ev.total_length, ev.value_length,
                            ev.value_start, ev.name_hash, ev.name_length, ev.name_start};
            m_tuser_reg <= ev.kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
